[design/pbu_pkg.sv]
// ----------------------------------------------------------------------------
// pbu_pkg
// shared constants and register codes of the pixel back-projection block
// ----------------------------------------------------------------------------
package pbu_pkg;

    localparam int ITERATIONS_DEF     = 10;
    localparam int NORM_FRAC_BITS_DEF = 16;

    localparam int PIX_W      = 16;
    localparam int DEPTH_W    = 16;
    localparam int POINT_W    = 22;
    localparam int COEF_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [POINT_W-1:0] POINT_MAX = 22'sh1FFFFF;
    localparam logic signed [POINT_W-1:0] POINT_MIN = -22'sh200000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL,
        REG_PRINCIPAL,
        REG_K1,
        REG_K2,
        REG_P1,
        REG_P2,
        REG_K3,
        REG_MODE
    } cfg_reg_t;

endpackage

[design/pbu_div_cell.sv]
// ----------------------------------------------------------------------------
// pbu_div_cell
// one restoring division step per cell, one quotient bit, registered
// ----------------------------------------------------------------------------
module pbu_div_cell #(
    parameter int LANES = 1,
    parameter int RW    = 8,
    parameter int DW    = 8,
    parameter int QB    = 8,
    parameter int BIT   = 0,
    parameter int PW    = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_i,
    input  logic [RW-1:0] rem_i [LANES],
    input  logic [DW-1:0] den_i [LANES],
    input  logic [QB-1:0] quo_i [LANES],
    input  logic [PW-1:0] pay_i,
    output logic          valid_o,
    output logic [RW-1:0] rem_o [LANES],
    output logic [DW-1:0] den_o [LANES],
    output logic [QB-1:0] quo_o [LANES],
    output logic [PW-1:0] pay_o
);

    localparam int CW = RW + DW;

    logic          valid_reg;
    logic [RW-1:0] rem_reg  [LANES];
    logic [DW-1:0] den_reg  [LANES];
    logic [QB-1:0] quo_reg  [LANES];
    logic [RW-1:0] rem_next [LANES];
    logic [QB-1:0] quo_next [LANES];
    logic [PW-1:0] pay_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [CW-1:0] dsh;
        logic [CW-1:0] rem_x;
        logic          fits;
        assign dsh         = CW'(den_i[l]) << BIT;
        assign rem_x       = CW'(rem_i[l]);
        assign fits        = rem_x >= dsh;
        assign rem_next[l] = fits ? RW'(rem_x - dsh) : rem_i[l];
        assign quo_next[l] = quo_i[l] | (fits ? (QB'(1) << BIT) : QB'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_i;
            quo_reg <= quo_next;
            pay_reg <= pay_i;
        end
    end

    assign valid_o = valid_reg;
    assign rem_o   = rem_reg;
    assign den_o   = den_reg;
    assign quo_o   = quo_reg;
    assign pay_o   = pay_reg;

endmodule

[design/pbu_div.sv]
// ----------------------------------------------------------------------------
// pbu_div
// pipelined unsigned divider, a chain of one-bit cells with sideband payload
// ----------------------------------------------------------------------------
module pbu_div #(
    parameter int LANES = 1,
    parameter int RW    = 8,
    parameter int DW    = 8,
    parameter int QB    = 8,
    parameter int PW    = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_i,
    input  logic [RW-1:0] num_i [LANES],
    input  logic [DW-1:0] den_i [LANES],
    input  logic [PW-1:0] pay_i,
    output logic          valid_o,
    output logic [QB-1:0] quo_o [LANES],
    output logic [PW-1:0] pay_o
);

    logic          valid_c [QB+1];
    logic [RW-1:0] rem_c   [QB+1][LANES];
    logic [DW-1:0] den_c   [QB+1][LANES];
    logic [QB-1:0] quo_c   [QB+1][LANES];
    logic [PW-1:0] pay_c   [QB+1];

    assign valid_c[0] = valid_i;
    assign rem_c[0]   = num_i;
    assign den_c[0]   = den_i;
    assign pay_c[0]   = pay_i;

    for (genvar l = 0; l < LANES; l++) begin : g_init
        assign quo_c[0][l] = '0;
    end

    for (genvar k = 0; k < QB; k++) begin : g_cell
        pbu_div_cell #(
            .LANES (LANES),
            .RW    (RW),
            .DW    (DW),
            .QB    (QB),
            .BIT   (QB - 1 - k),
            .PW    (PW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid_i (valid_c[k]),
            .rem_i   (rem_c[k]),
            .den_i   (den_c[k]),
            .quo_i   (quo_c[k]),
            .pay_i   (pay_c[k]),
            .valid_o (valid_c[k+1]),
            .rem_o   (rem_c[k+1]),
            .den_o   (den_c[k+1]),
            .quo_o   (quo_c[k+1]),
            .pay_o   (pay_c[k+1])
        );
    end

    assign valid_o = valid_c[QB];
    assign quo_o   = quo_c[QB];
    assign pay_o   = pay_c[QB];

endmodule

[design/pbu_iter_cell.sv]
// ----------------------------------------------------------------------------
// pbu_iter_cell
// one undistortion refinement pass, pipelined, with its own 1/den divider
// ----------------------------------------------------------------------------
module pbu_iter_cell #(
    parameter int F  = pbu_pkg::NORM_FRAC_BITS_DEF,
    parameter int PW = 1,
    localparam int QW = F + 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic signed [QW-1:0] k1,
    input  logic signed [QW-1:0] k2,
    input  logic signed [QW-1:0] k3,
    input  logic signed [QW-1:0] p1,
    input  logic signed [QW-1:0] p2,
    input  logic                 valid_i,
    input  logic signed [QW-1:0] x0_i,
    input  logic signed [QW-1:0] y0_i,
    input  logic signed [QW-1:0] x_i,
    input  logic signed [QW-1:0] y_i,
    input  logic [PW-1:0]        pay_i,
    output logic                 valid_o,
    output logic signed [QW-1:0] x0_o,
    output logic signed [QW-1:0] y0_o,
    output logic signed [QW-1:0] x_o,
    output logic signed [QW-1:0] y_o,
    output logic [PW-1:0]        pay_o
);

    localparam int W2  = 2 * QW + 2;
    localparam int RW  = 2 * F + 1;
    localparam int DW  = F + 7;
    localparam int QB  = F + 5;
    localparam int DPW = 4 * QW + PW;

    localparam longint LIM_L  = (64'sd1 <<< (F + 7)) - 64'sd1;
    localparam longint XLIM_L = (64'sd1 <<< (F + 2)) - 64'sd1;

    localparam logic signed [QW-1:0] LIM_Q     = QW'(LIM_L);
    localparam logic signed [QW-1:0] XLIM_Q    = QW'(XLIM_L);
    localparam logic signed [QW-1:0] ONE_Q     = QW'(64'sd1 <<< F);
    localparam logic signed [QW-1:0] DEN_MIN_Q = QW'(64'sd1 <<< (F - 4));
    localparam logic signed [W2-1:0] LIM_W     = W2'(LIM_L);
    localparam logic signed [W2-1:0] DEN_MIN_W = W2'(DEN_MIN_Q);

    typedef struct packed {
        logic signed [QW-1:0] x0;
        logic signed [QW-1:0] y0;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] r2;
        logic signed [QW-1:0] den;
        logic [PW-1:0]        pay;
    } carry_t;

    function automatic logic signed [QW-1:0] sat_q(input logic signed [W2-1:0] v);
        logic signed [QW-1:0] r;
        priority if (v > LIM_W)
            r = LIM_Q;
        else if (v < -LIM_W)
            r = -LIM_Q;
        else
            r = QW'(v);
        return r;
    endfunction

    function automatic logic signed [QW-1:0] mul_q(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
        logic signed [W2-1:0] p;
        p = W2'(a) * W2'(b);
        return sat_q(p >>> F);
    endfunction

    function automatic logic signed [QW-1:0] add_q(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
        return sat_q(W2'(a) + W2'(b));
    endfunction

    function automatic logic signed [QW-1:0] r2_plus(input logic signed [QW-1:0] r2,
                                                     input logic signed [QW-1:0] sq);
        return sat_q(W2'(r2) + (W2'(sq) <<< 1));
    endfunction

    function automatic logic signed [QW-1:0] clamp_x(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] r;
        priority if (v > XLIM_Q)
            r = XLIM_Q;
        else if (v < -XLIM_Q)
            r = -XLIM_Q;
        else
            r = v;
        return r;
    endfunction

    logic [7:0] v_reg;

    carry_t c1_next, c2_next, c3_next, c4_next, c5_next, c6_next, c7_next, c8_next;
    carry_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg, c8_reg;

    logic signed [QW-1:0] a_next, a_reg;
    logic signed [QW-1:0] b_next, b_reg;
    logic signed [W2-1:0] den_sum;
    logic signed [QW-1:0] xq_next, xq_reg, yq_next, yq_reg;
    logic signed [QW-1:0] xy_next, xy_reg, xx_next, xx_reg, yy_next, yy_reg;
    logic signed [QW-1:0] t1_next, t1_reg, t2_next, t2_reg;
    logic signed [QW-1:0] t3_next, t3_reg, t4_next, t4_reg;
    logic signed [QW-1:0] dx, dy;
    logic signed [QW-1:0] ex_next, ex_reg, ey_next, ey_reg;

    logic [RW-1:0]  div_num [1];
    logic [DW-1:0]  div_den [1];
    logic [QB-1:0]  div_quo [1];
    logic [DPW-1:0] div_pay_i, div_pay_o;
    logic           div_valid;

    logic signed [QW-1:0] ex_d, ey_d, x0_d, y0_d;
    logic [PW-1:0]        pay_d;
    logic signed [QW-1:0] icd;
    logic signed [QW-1:0] x_next, y_next;

    logic                 valid_reg;
    logic signed [QW-1:0] x0_reg, y0_reg, x_reg, y_reg;
    logic [PW-1:0]        pay_reg;

    // radial terms
    always_comb
    begin
        c1_next     = '0;
        c1_next.x0  = x0_i;
        c1_next.y0  = y0_i;
        c1_next.x   = x_i;
        c1_next.y   = y_i;
        c1_next.pay = pay_i;
        c1_next.r2  = sat_q((W2'(x_i) * W2'(x_i) + W2'(y_i) * W2'(y_i)) >>> F);

        c2_next = c1_reg;
        a_next  = add_q(mul_q(k3, c1_reg.r2), k2);

        c3_next = c2_reg;
        b_next  = add_q(mul_q(a_reg, c2_reg.r2), k1);

        c4_next = c3_reg;
        den_sum = W2'(ONE_Q) + W2'(mul_q(b_reg, c3_reg.r2));
        priority if (den_sum < DEN_MIN_W)
            c4_next.den = DEN_MIN_Q;
        else if (den_sum > LIM_W)
            c4_next.den = LIM_Q;
        else
            c4_next.den = QW'(den_sum);
    end

    // tangential terms
    always_comb
    begin
        c5_next = c4_reg;
        xq_next = mul_q(c4_reg.x, c4_reg.den);
        yq_next = mul_q(c4_reg.y, c4_reg.den);

        c6_next = c5_reg;
        xy_next = mul_q(xq_reg, yq_reg);
        xx_next = mul_q(xq_reg, xq_reg);
        yy_next = mul_q(yq_reg, yq_reg);

        c7_next = c6_reg;
        t1_next = mul_q(p1, xy_reg);
        t2_next = mul_q(p2, r2_plus(c6_reg.r2, xx_reg));
        t3_next = mul_q(p2, xy_reg);
        t4_next = mul_q(p1, r2_plus(c6_reg.r2, yy_reg));

        c8_next = c7_reg;
        dx      = sat_q((W2'(t1_reg) <<< 1) + W2'(t2_reg));
        dy      = sat_q((W2'(t3_reg) <<< 1) + W2'(t4_reg));
        ex_next = sat_q(W2'(c7_reg.x0) - W2'(dx));
        ey_next = sat_q(W2'(c7_reg.y0) - W2'(dy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[6:0], valid_i};
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= c1_next;
            c2_reg  <= c2_next;
            c3_reg  <= c3_next;
            c4_reg  <= c4_next;
            c5_reg  <= c5_next;
            c6_reg  <= c6_next;
            c7_reg  <= c7_next;
            c8_reg  <= c8_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            xq_reg  <= xq_next;
            yq_reg  <= yq_next;
            xy_reg  <= xy_next;
            xx_reg  <= xx_next;
            yy_reg  <= yy_next;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            t3_reg  <= t3_next;
            t4_reg  <= t4_next;
            ex_reg  <= ex_next;
            ey_reg  <= ey_next;
            x0_reg  <= x0_d;
            y0_reg  <= y0_d;
            x_reg   <= x_next;
            y_reg   <= y_next;
            pay_reg <= pay_d;
        end
    end

    // reciprocal of the distortion denominator
    assign div_num[0] = RW'(1) << (2 * F);
    assign div_den[0] = DW'(c8_reg.den);
    assign div_pay_i  = {ex_reg, ey_reg, c8_reg.x0, c8_reg.y0, c8_reg.pay};

    pbu_div #(
        .LANES (1),
        .RW    (RW),
        .DW    (DW),
        .QB    (QB),
        .PW    (DPW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (v_reg[7]),
        .num_i   (div_num),
        .den_i   (div_den),
        .pay_i   (div_pay_i),
        .valid_o (div_valid),
        .quo_o   (div_quo),
        .pay_o   (div_pay_o)
    );

    assign {ex_d, ey_d, x0_d, y0_d, pay_d} = div_pay_o;
    assign icd    = $signed(QW'(div_quo[0]));
    assign x_next = clamp_x(mul_q(ex_d, icd));
    assign y_next = clamp_x(mul_q(ey_d, icd));

    assign valid_o = valid_reg;
    assign x0_o    = x0_reg;
    assign y0_o    = y0_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign pay_o   = pay_reg;

endmodule

[design/pixel_backproject_undistort.sv]
// ----------------------------------------------------------------------------
// pixel_backproject_undistort
// a chain of input register, one-bit-per-stage front divider, start-point register,
// ITERATIONS pass cells with their own dividers, and output register
// throughput one transfer per cycle unless a stalled output freezes the whole pipeline
// reset clears all valid bits and the configuration registers to zero
// ----------------------------------------------------------------------------
module pixel_backproject_undistort #(
    parameter int ITERATIONS     = pbu_pkg::ITERATIONS_DEF,
    parameter int NORM_FRAC_BITS = pbu_pkg::NORM_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pbu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pbu_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  logic [pbu_pkg::PIX_W-1:0]             pixel_u,
    input  logic [pbu_pkg::PIX_W-1:0]             pixel_v,
    input  logic [pbu_pkg::DEPTH_W-1:0]           depth,
    output logic                                  point_valid,
    input  logic                                  point_stall,
    output logic signed [pbu_pkg::POINT_W-1:0]    point_x,
    output logic signed [pbu_pkg::POINT_W-1:0]    point_y,
    output logic [pbu_pkg::DEPTH_W-1:0]           point_z
);

    localparam int F     = NORM_FRAC_BITS;
    localparam int QW    = F + 8;
    localparam int PIX_W = pbu_pkg::PIX_W;
    localparam int DW    = pbu_pkg::DEPTH_W;
    localparam int PTW   = pbu_pkg::POINT_W;
    localparam int CFW   = pbu_pkg::COEF_W;
    localparam int QB    = (16 + F > 36) ? 16 + F : 36;
    localparam int FPW   = 4 + DW;
    localparam int PW    = DW + 2 * PTW;
    localparam int PRW   = QW + DW + 1;

    localparam longint XLIM_L = (64'sd1 <<< (F + 2)) - 64'sd1;
    localparam logic signed [QW-1:0] XLIM_Q = QW'(XLIM_L);

    // configuration
    logic [31:0]           focal_reg;
    logic [31:0]           principal_reg;
    logic signed [CFW-1:0] coef_raw [5];
    logic signed [QW-1:0]  coef_q   [5];
    logic                  lens_mode_reg;

    logic en;

    // front stage
    logic [PIX_W-1:0]      fx, fy, cx, cy;
    logic signed [PIX_W:0] du, dv;
    logic [PIX_W-1:0]      mag_u, mag_v;
    logic [31:0]           prod_u, prod_v;
    logic [QB-1:0]         num_u_next, num_v_next;

    logic                  a_valid_reg;
    logic [QB-1:0]         a_num_reg [2];
    logic [PIX_W-1:0]      a_den     [2];
    logic [FPW-1:0]        a_pay_reg;

    logic                  fd_valid;
    logic [QB-1:0]         fd_quo [2];
    logic [FPW-1:0]        fd_pay;
    logic                  neg_u, neg_v, zero_u, zero_v;
    logic [DW-1:0]         fd_depth;
    logic signed [QB:0]    qs_u, qs_v;
    logic signed [PTW-1:0] px_next, py_next;
    logic signed [QW-1:0]  x0_next, y0_next;

    logic                  b_valid_reg;
    logic signed [QW-1:0]  b_x0_reg, b_y0_reg;
    logic [PW-1:0]         b_pay_reg;

    logic                  it_valid [ITERATIONS+1];
    logic signed [QW-1:0]  it_x0    [ITERATIONS+1];
    logic signed [QW-1:0]  it_y0    [ITERATIONS+1];
    logic signed [QW-1:0]  it_x     [ITERATIONS+1];
    logic signed [QW-1:0]  it_y     [ITERATIONS+1];
    logic [PW-1:0]         it_pay   [ITERATIONS+1];

    logic [DW-1:0]         e_depth;
    logic signed [PTW-1:0] e_px, e_py;
    logic signed [PRW-1:0] prod_x, prod_y, sh_x, sh_y;
    logic signed [PTW-1:0] ux_next, uy_next;

    logic                  point_valid_reg;
    logic signed [PTW-1:0] point_x_reg, point_y_reg;
    logic [DW-1:0]         point_z_reg;

    function automatic logic signed [PTW-1:0] clamp_pt(input logic signed [PRW-1:0] v);
        logic signed [PTW-1:0] r;
        priority if (v > PRW'(pbu_pkg::POINT_MAX))
            r = pbu_pkg::POINT_MAX;
        else if (v < PRW'(pbu_pkg::POINT_MIN))
            r = pbu_pkg::POINT_MIN;
        else
            r = PTW'(v);
        return r;
    endfunction

    function automatic logic signed [PTW-1:0] clamp_q_pt(input logic signed [QB:0] v);
        logic signed [PTW-1:0] r;
        priority if (v > (QB+1)'(pbu_pkg::POINT_MAX))
            r = pbu_pkg::POINT_MAX;
        else if (v < (QB+1)'(pbu_pkg::POINT_MIN))
            r = pbu_pkg::POINT_MIN;
        else
            r = PTW'(v);
        return r;
    endfunction

    function automatic logic signed [QW-1:0] clamp_q_x(input logic signed [QB:0] v);
        logic signed [QW-1:0] r;
        priority if (v > (QB+1)'(XLIM_Q))
            r = XLIM_Q;
        else if (v < -((QB+1)'(XLIM_Q)))
            r = -XLIM_Q;
        else
            r = QW'(v);
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg     <= '0;
            principal_reg <= '0;
            coef_raw[0]   <= '0;
            coef_raw[1]   <= '0;
            coef_raw[2]   <= '0;
            coef_raw[3]   <= '0;
            coef_raw[4]   <= '0;
            lens_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pbu_pkg::cfg_reg_t'(cfg_index))
                pbu_pkg::REG_FOCAL:     focal_reg     <= cfg_data;
                pbu_pkg::REG_PRINCIPAL: principal_reg <= cfg_data;
                pbu_pkg::REG_K1:        coef_raw[0]   <= $signed(cfg_data[CFW-1:0]);
                pbu_pkg::REG_K2:        coef_raw[1]   <= $signed(cfg_data[CFW-1:0]);
                pbu_pkg::REG_P1:        coef_raw[2]   <= $signed(cfg_data[CFW-1:0]);
                pbu_pkg::REG_P2:        coef_raw[3]   <= $signed(cfg_data[CFW-1:0]);
                pbu_pkg::REG_K3:        coef_raw[4]   <= $signed(cfg_data[CFW-1:0]);
                pbu_pkg::REG_MODE:      lens_mode_reg <= cfg_data[0];
                default:                lens_mode_reg <= lens_mode_reg;
            endcase
        end
    end

    // coefficients from Q2.16 to the working fraction
    for (genvar i = 0; i < 5; i++) begin : g_coef
        if (F >= 16) begin : g_up
            assign coef_q[i] = QW'(coef_raw[i]) <<< (F - 16);
        end
        else begin : g_down
            assign coef_q[i] = QW'(coef_raw[i] >>> (16 - F));
        end
    end

    assign en          = !point_valid_reg || !point_stall;
    assign pixel_stall = !en;

    assign fx = focal_reg[15:0];
    assign fy = focal_reg[31:16];
    assign cx = principal_reg[15:0];
    assign cy = principal_reg[31:16];

    always_comb
    begin
        du     = $signed({1'b0, pixel_u}) - $signed({1'b0, cx});
        dv     = $signed({1'b0, pixel_v}) - $signed({1'b0, cy});
        mag_u  = du[PIX_W] ? PIX_W'(-du) : du[PIX_W-1:0];
        mag_v  = dv[PIX_W] ? PIX_W'(-dv) : dv[PIX_W-1:0];
        prod_u = mag_u * depth;
        prod_v = mag_v * depth;
        if (lens_mode_reg)
        begin
            num_u_next = QB'(mag_u) << F;
            num_v_next = QB'(mag_v) << F;
        end
        else
        begin
            num_u_next = QB'(prod_u) << 4;
            num_v_next = QB'(prod_v) << 4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            point_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg     <= pixel_valid;
            b_valid_reg     <= fd_valid;
            point_valid_reg <= it_valid[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_reg[0] <= num_u_next;
            a_num_reg[1] <= num_v_next;
            a_pay_reg    <= {du[PIX_W], dv[PIX_W], fx == '0, fy == '0, depth};
            b_x0_reg     <= x0_next;
            b_y0_reg     <= y0_next;
            b_pay_reg    <= {fd_depth, px_next, py_next};
            point_x_reg  <= lens_mode_reg ? ux_next : e_px;
            point_y_reg  <= lens_mode_reg ? uy_next : e_py;
            point_z_reg  <= e_depth;
        end
    end

    assign a_den[0] = fx;
    assign a_den[1] = fy;

    pbu_div #(
        .LANES (2),
        .RW    (QB),
        .DW    (PIX_W),
        .QB    (QB),
        .PW    (FPW)
    ) u_front_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (a_valid_reg),
        .num_i   (a_num_reg),
        .den_i   (a_den),
        .pay_i   (a_pay_reg),
        .valid_o (fd_valid),
        .quo_o   (fd_quo),
        .pay_o   (fd_pay)
    );

    // signed quotients, pinhole result and normalized start point
    always_comb
    begin
        {neg_u, neg_v, zero_u, zero_v, fd_depth} = fd_pay;
        qs_u = neg_u ? -$signed({1'b0, fd_quo[0]}) : $signed({1'b0, fd_quo[0]});
        qs_v = neg_v ? -$signed({1'b0, fd_quo[1]}) : $signed({1'b0, fd_quo[1]});
        if (zero_u)
        begin
            qs_u = '0;
        end
        if (zero_v)
        begin
            qs_v = '0;
        end
        px_next = clamp_q_pt(qs_u);
        py_next = clamp_q_pt(qs_v);
        x0_next = clamp_q_x(qs_u);
        y0_next = clamp_q_x(qs_v);
    end

    assign it_valid[0] = b_valid_reg;
    assign it_x0[0]    = b_x0_reg;
    assign it_y0[0]    = b_y0_reg;
    assign it_x[0]     = b_x0_reg;
    assign it_y[0]     = b_y0_reg;
    assign it_pay[0]   = b_pay_reg;

    for (genvar n = 0; n < ITERATIONS; n++) begin : g_iter
        pbu_iter_cell #(
            .F  (F),
            .PW (PW)
        ) u_iter (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .k1      (coef_q[0]),
            .k2      (coef_q[1]),
            .k3      (coef_q[4]),
            .p1      (coef_q[2]),
            .p2      (coef_q[3]),
            .valid_i (it_valid[n]),
            .x0_i    (it_x0[n]),
            .y0_i    (it_y0[n]),
            .x_i     (it_x[n]),
            .y_i     (it_y[n]),
            .pay_i   (it_pay[n]),
            .valid_o (it_valid[n+1]),
            .x0_o    (it_x0[n+1]),
            .y0_o    (it_y0[n+1]),
            .x_o     (it_x[n+1]),
            .y_o     (it_y[n+1]),
            .pay_o   (it_pay[n+1])
        );
    end

    // scale the refined point by depth
    always_comb
    begin
        {e_depth, e_px, e_py} = it_pay[ITERATIONS];
        prod_x  = PRW'(it_x[ITERATIONS]) * PRW'($signed({1'b0, e_depth}));
        prod_y  = PRW'(it_y[ITERATIONS]) * PRW'($signed({1'b0, e_depth}));
        sh_x    = prod_x >>> (F - 4);
        sh_y    = prod_y >>> (F - 4);
        ux_next = clamp_pt(sh_x);
        uy_next = clamp_pt(sh_y);
    end

    assign point_valid = point_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_z     = point_z_reg;

endmodule
